// File: src/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mamc_pkg.sv
// Package: types, codes and helper functions of the motion alarm mode controller.
package mamc_pkg;

    localparam int TIME_W = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SELFTEST_TIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALERT_TIME    = 1'b1;

    localparam logic [TIME_W-1:0] SELFTEST_TIME_RST = 16'd3000;
    localparam logic [TIME_W-1:0] ALERT_TIME_RST    = 16'd10000;

    typedef enum logic [2:0] {
        MODE_SELFTEST = 3'd0,
        MODE_IDLE     = 3'd1,
        MODE_ALERT    = 3'd2,
        MODE_PIRFAULT = 3'd3,
        MODE_NETDOWN  = 3'd4,
        MODE_BOTH     = 3'd5,
        MODE_OFF      = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        LED_BOOT     = 3'd0,
        LED_NORMAL   = 3'd1,
        LED_NETFAULT = 3'd2,
        LED_PIRFAULT = 3'd3,
        LED_BOTH     = 3'd4,
        LED_OFF      = 3'd5
    } t_led;

    typedef struct packed {
        logic [7:0] elapsed_ms;
        logic       short_press;
        logic       long_press;
        logic       motion_seen;
        logic       sensor_fault;
        logic       net_up;
    } t_in_item;

    typedef struct packed {
        logic [2:0] led_status;
        logic       alert_on;
        logic       powered;
        logic [2:0] mode_code;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0] selftest_time_ms;
        logic [TIME_W-1:0] alert_time_ms;
    } t_cfg;

    typedef struct packed {
        logic  power_flag;
        t_mode mode;
    } t_mode_state;

    function automatic t_mode health_mode(input logic fault, input logic net);
        t_mode m;
        if (fault && !net) begin
            m = MODE_BOTH;
        end else if (fault) begin
            m = MODE_PIRFAULT;
        end else if (!net) begin
            m = MODE_NETDOWN;
        end else begin
            m = MODE_IDLE;
        end
        return m;
    endfunction

    function automatic t_led led_of_mode(input t_mode m);
        t_led l;
        case (m)
            MODE_SELFTEST: l = LED_BOOT;
            MODE_IDLE:     l = LED_NORMAL;
            MODE_ALERT:    l = LED_NORMAL;
            MODE_PIRFAULT: l = LED_PIRFAULT;
            MODE_NETDOWN:  l = LED_NETFAULT;
            MODE_BOTH:     l = LED_BOTH;
            default:       l = LED_OFF;
        endcase
        return l;
    endfunction

endpackage

// File: src/mamc_cfg.sv
// Configuration register file: self-test and alert durations.
module mamc_cfg
    import mamc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  logic [TIME_W-1:0]    i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.selftest_time_ms <= SELFTEST_TIME_RST;
            r_cfg.alert_time_ms    <= ALERT_TIME_RST;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_SELFTEST_TIME: r_cfg.selftest_time_ms <= i_data;
                CFG_ALERT_TIME:    r_cfg.alert_time_ms    <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/mamc_mode.sv
// Mode state machine: power flag, mode, time-in-mode counter and result logic.
module mamc_mode
    import mamc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_in_item    i_item,
    input  t_cfg        i_cfg,
    output t_out_item   o_result,
    output t_mode_state o_state
);

    logic              r_power;
    t_mode             r_mode;
    logic [TIME_W-1:0] r_time;

    logic              n_power;
    t_mode             n_mode;
    logic [TIME_W-1:0] n_time;

    logic [TIME_W:0]   time_sum;
    logic [TIME_W-1:0] time_sat;
    t_mode             mode_a;
    logic [TIME_W-1:0] time_a;
    t_mode             hmode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power <= 1'b1;
            r_mode  <= MODE_SELFTEST;
            r_time  <= '0;
        end else if (i_step) begin
            r_power <= n_power;
            r_mode  <= n_mode;
            r_time  <= n_time;
        end
    end

    always_comb begin
        time_sum = {1'b0, r_time} + {{(TIME_W-8+1){1'b0}}, i_item.elapsed_ms};
        time_sat = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];
        hmode    = health_mode(i_item.sensor_fault, i_item.net_up);

        n_power = r_power;
        mode_a  = r_mode;
        time_a  = time_sat;
        if (!i_item.long_press && i_item.short_press) begin
            n_power = !r_power;
            mode_a  = n_power ? MODE_SELFTEST : MODE_OFF;
            if (mode_a != r_mode) begin
                time_a = '0;
            end
        end

        n_mode = mode_a;
        if (n_power) begin
            unique case (mode_a) inside
                MODE_SELFTEST: begin
                    if (time_a >= i_cfg.selftest_time_ms) n_mode = MODE_IDLE;
                end
                MODE_IDLE: begin
                    n_mode = (hmode == MODE_IDLE && i_item.motion_seen) ? MODE_ALERT : hmode;
                end
                MODE_ALERT: begin
                    if (i_item.sensor_fault) begin
                        n_mode = MODE_PIRFAULT;
                    end else if (time_a >= i_cfg.alert_time_ms) begin
                        n_mode = hmode;
                    end
                end
                MODE_PIRFAULT, MODE_NETDOWN, MODE_BOTH: n_mode = hmode;
                default: n_mode = mode_a;
            endcase
        end
        n_time = (n_mode != mode_a) ? '0 : time_a;

        if (n_power) begin
            o_result.led_status = led_of_mode(n_mode);
            o_result.alert_on   = (n_mode == MODE_ALERT);
            o_result.powered    = 1'b1;
            o_result.mode_code  = n_mode;
        end else begin
            o_result.led_status = LED_OFF;
            o_result.alert_on   = 1'b0;
            o_result.powered    = 1'b0;
            o_result.mode_code  = MODE_OFF;
        end
    end

    assign o_state.power_flag = r_power;
    assign o_state.mode       = r_mode;

endmodule

// File: src/motion_alarm_mode_controller.sv
// Top level of the motion alarm mode controller: input stage, mode logic, result stage.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+----------------------------
//  in      | in  | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  out     | out | o_out_valid / i_out_ready | o_out_data (t_out_item)
//  cfg     | in  | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One poll per cycle unless the output stalls; a beat passes the input register, then
// the mode update into the result register, which also updates the mode state.
// Reset is synchronous; config returns to 3000 / 10000 ms, power on, self-test.
// A stall on the output holds both stages; the input is ready while the input
// register is empty or moves on into the result register.
`include "assert_macros.svh"

module motion_alarm_mode_controller
    import mamc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TIME_W-1:0]    i_cfg_data
);

    logic        r_s1_valid;
    t_in_item    r_s1_data;
    logic        r_out_valid;
    t_out_item   r_out_data;

    logic        out_free;
    logic        s1_adv;
    logic        in_acc;
    t_cfg        cfg;
    t_out_item   result;
    t_mode_state mstate;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    mamc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    mamc_mode u_mode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_adv),
        .i_item   (r_s1_data),
        .i_cfg    (cfg),
        .o_result (result),
        .o_state  (mstate)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ASSERT_IMPL(a_off_mode, !mstate.power_flag, mstate.mode == MODE_OFF, "mode not off")
    `ASSERT_IMPL(a_on_mode, mstate.power_flag, mstate.mode != MODE_OFF, "mode off while on")
    `ASSERT_IMPL(a_alert_pwr, r_out_valid && r_out_data.alert_on, r_out_data.powered, "bad alert")
    `ASSERT_NEXT(a_s1_moves, s1_adv, r_out_valid, "advanced beat missing from result stage")

endmodule

// File: tb/motion_alarm_mode_controller_test.sv
// Testbench for the motion alarm mode controller: scoreboard, stimulus and result checks.
`timescale 1ns / 1ps

module motion_alarm_mode_controller_test;
    import mamc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    class mode_scoreboard;
        logic [TIME_W-1:0] selftest_ms;
        logic [TIME_W-1:0] alert_ms;
        logic              power_on;
        t_mode             cur_mode;
        logic [TIME_W-1:0] mode_ms;
        t_out_item         pending_results[$];
        int unsigned       mismatches;

        function new();
            selftest_ms = SELFTEST_TIME_RST;
            alert_ms    = ALERT_TIME_RST;
            power_on    = 1'b1;
            cur_mode    = MODE_SELFTEST;
            mode_ms     = '0;
            mismatches  = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
            if (idx == CFG_SELFTEST_TIME) begin
                selftest_ms = val;
            end else begin
                alert_ms = val;
            end
        endfunction

        function void enter(t_mode next);
            if (next != cur_mode) begin
                cur_mode = next;
                mode_ms  = '0;
            end
        endfunction

        function t_mode health_target(logic fault, logic net);
            if (fault && !net) return MODE_BOTH;
            if (fault) return MODE_PIRFAULT;
            if (!net) return MODE_NETDOWN;
            return MODE_IDLE;
        endfunction

        function void note_poll(t_in_item it);
            logic [TIME_W:0] sum;
            t_out_item       res;
            t_led            led;
            sum     = {1'b0, mode_ms} + it.elapsed_ms;
            mode_ms = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            if (!it.long_press && it.short_press) begin
                power_on = ~power_on;
                enter(power_on ? MODE_SELFTEST : MODE_OFF);
            end
            if (power_on) begin
                case (cur_mode) inside
                    MODE_SELFTEST: begin
                        if (mode_ms >= selftest_ms) enter(MODE_IDLE);
                    end
                    MODE_IDLE: begin
                        enter(health_target(it.sensor_fault, it.net_up));
                        if (cur_mode == MODE_IDLE && it.motion_seen) enter(MODE_ALERT);
                    end
                    MODE_ALERT: begin
                        if (it.sensor_fault) begin
                            enter(MODE_PIRFAULT);
                        end else if (mode_ms >= alert_ms) begin
                            enter(health_target(it.sensor_fault, it.net_up));
                        end
                    end
                    MODE_PIRFAULT, MODE_NETDOWN, MODE_BOTH: begin
                        enter(health_target(it.sensor_fault, it.net_up));
                    end
                    default: ;
                endcase
                case (cur_mode) inside
                    MODE_SELFTEST:          led = LED_BOOT;
                    MODE_IDLE, MODE_ALERT:  led = LED_NORMAL;
                    MODE_PIRFAULT:          led = LED_PIRFAULT;
                    MODE_NETDOWN:           led = LED_NETFAULT;
                    MODE_BOTH:              led = LED_BOTH;
                    default:                led = LED_OFF;
                endcase
                res.led_status = led;
                res.alert_on   = (cur_mode == MODE_ALERT);
                res.powered    = 1'b1;
                res.mode_code  = cur_mode;
            end else begin
                res.led_status = LED_OFF;
                res.alert_on   = 1'b0;
                res.powered    = 1'b0;
                res.mode_code  = MODE_OFF;
            end
            pending_results.push_back(res);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending: %h", got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            check_field("led_status", want.led_status, got.led_status);
            check_field("alert_on", want.alert_on, got.alert_on);
            check_field("powered", want.powered, got.powered);
            check_field("mode_code", want.mode_code, got.mode_code);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data  = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [TIME_W-1:0]    i_cfg_data = '0;

    mode_scoreboard sb = new();
    int unsigned    sender_idle_pct    = 0;
    int unsigned    receiver_stall_pct = 0;
    int unsigned    hold_left          = 0;
    int unsigned    cycle_count        = 0;

    motion_alarm_mode_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // receiver: long hold-off when requested, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_poll(i_in_data);
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
        end
    end

    function automatic t_in_item make_poll(logic [7:0] el, logic sp, logic lp, logic mot,
                                           logic flt, logic net);
        t_in_item it;
        it.elapsed_ms   = el;
        it.short_press  = sp;
        it.long_press   = lp;
        it.motion_seen  = mot;
        it.sensor_fault = flt;
        it.net_up       = net;
        return it;
    endfunction

    function automatic t_in_item random_poll(int unsigned press_pct, int unsigned fault_pct,
                                             int unsigned full_pct);
        t_in_item it;
        if ($urandom_range(99) < full_pct) begin
            it.elapsed_ms = 8'hFF;
        end else if ($urandom_range(1) == 0) begin
            it.elapsed_ms = 8'($urandom_range(15));
        end else begin
            it.elapsed_ms = 8'($urandom_range(255));
        end
        it.short_press  = ($urandom_range(99) < press_pct);
        it.long_press   = ($urandom_range(99) < press_pct);
        it.motion_seen  = ($urandom_range(99) < 30);
        it.sensor_fault = ($urandom_range(99) < fault_pct);
        it.net_up       = ($urandom_range(99) >= 15);
        return it;
    endfunction

    task automatic send_poll(input t_in_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_register(idx, val);
        @(posedge i_clk);
    endtask

    task automatic set_times(input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] al);
        drain();
        write_register(CFG_SELFTEST_TIME, st);
        write_register(CFG_ALERT_TIME, al);
    endtask

    task automatic run_phase(input int unsigned n, input int unsigned snd_idle,
                             input int unsigned rcv_stall, input int unsigned press_pct,
                             input int unsigned fault_pct, input int unsigned full_pct);
        sender_idle_pct    = snd_idle;
        receiver_stall_pct = rcv_stall;
        repeat (n) send_poll(random_poll(press_pct, fault_pct, full_pct));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset timing
        sender_idle_pct    = 20;
        receiver_stall_pct = 20;
        send_poll(make_poll(8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_poll(make_poll(8'd255, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
        send_poll(make_poll(8'd0,   1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_poll(make_poll(8'd255, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        send_poll(make_poll(8'd10,  1'b1, 1'b0, 1'b0, 1'b0, 1'b1));

        // directed, zero timeouts: every mode and the fault priorities
        set_times('0, '0);
        send_poll(make_poll(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_poll(make_poll(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_poll(make_poll(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_poll(make_poll(8'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_poll(make_poll(8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_poll(make_poll(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_poll(make_poll(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        send_poll(make_poll(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_poll(make_poll(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        send_poll(make_poll(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_poll(make_poll(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_poll(make_poll(8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_poll(make_poll(8'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_poll(make_poll(8'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));

        // directed, maximum timeouts
        set_times('1, '1);
        send_poll(make_poll(8'd255, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_poll(make_poll(8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_poll(make_poll(8'd0,   1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_poll(make_poll(8'd0,   1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_poll(make_poll(8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));

        set_times(16'd500, 16'd800);
        run_phase(130, 0, 0, 3, 15, 10);

        set_times('0, '0);
        run_phase(130, 66, 0, 5, 20, 10);

        // long polls, no presses or faults: counter saturates at the maximum timeout
        set_times('1, '1);
        run_phase(350, 0, 66, 0, 0, 90);

        set_times(16'($urandom_range(3000)), 16'($urandom_range(3000)));
        run_phase(130, 10, 10, 3, 15, 20);

        // output held off while input keeps offering
        set_times(SELFTEST_TIME_RST, ALERT_TIME_RST);
        hold_left = 300;
        run_phase(40, 0, 0, 2, 10, 50);
        run_phase(90, 30, 30, 2, 10, 50);

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: motion_alarm_mode_controller.f
+incdir+src
src/mamc_pkg.sv
src/mamc_cfg.sv
src/mamc_mode.sv
src/motion_alarm_mode_controller.sv
tb/motion_alarm_mode_controller_test.sv
